@@ rtl/tsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, codes and helpers of the turtle segment generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

   localparam int          STACK_DEPTH_DEFAULT     = 32;
   localparam int          FLOWER_SEGMENTS_DEFAULT = 8;

   localparam logic [63:0] SYMBOL_CODES_RESET  = 64'd6727107001848981062;
   localparam logic [23:0] STEP_LENGTH_RESET   = 24'd65536;
   localparam logic [15:0] TURN_ANGLE_RESET    = 16'd4551;
   localparam logic [23:0] FLOWER_RADIUS_RESET = 24'd32768;
   localparam logic [15:0] HEADING_RESET       = 16'd16384;
   localparam logic [17:0] STEM_FRAC           = 18'd39322;

   typedef enum logic [1:0] {
      CSR_SYMBOL_CODES  = 2'd0,
      CSR_STEP_LENGTH   = 2'd1,
      CSR_TURN_ANGLE    = 2'd2,
      CSR_FLOWER_RADIUS = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      CMD_DRAW   = 4'd0,
      CMD_MOVE   = 4'd1,
      CMD_FLOWER = 4'd2,
      CMD_LEFT   = 4'd3,
      CMD_RIGHT  = 4'd4,
      CMD_AROUND = 4'd5,
      CMD_PUSH   = 4'd6,
      CMD_POP    = 4'd7,
      CMD_NONE   = 4'd8
   } cmd_type;

   typedef struct packed {
      logic               start_word;
      cmd_type            cmd;
      logic               has_scale;
      logic signed [15:0] length_scale;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_TRIG,
      ST_PROJ,
      ST_NEXT,
      ST_POP
   } state_type;

   // clamp a 37-bit signed sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (&v[36:31] || ~|v[36:31]) begin
         r = v[31:0];
      end else if (v[36]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/turtle_segment_generator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_segment_generator_core
// 2D turtle interpreter that turns L-system symbols into line segments.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | start_word, letter, has_scale, length_scale
//  rsp_    | out       | rsp_valid/rsp_stall | start/end x,y, flower_mesh, last_segment
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  Turns, push and unknown letters finish in the idle state, pop reads the stack
//  in ST_POP, move and draw pass ST_LEN, ST_TRIG, ST_PROJ and ST_NEXT. In a flower
//  every point needs two sine evaluations on the one shared multiplier.
//  Reset is synchronous; the stack memory needs no clearing pass.
//  A two-entry queue lets requests arrive while the back end is busy; a
//  stalled result holds in the output register until taken.
// ----------------------------------------------------------------------------
module turtle_segment_generator_core
   import tsg_pkg::*;
#(
   parameter int STACK_DEPTH     = STACK_DEPTH_DEFAULT,
   parameter int FLOWER_SEGMENTS = FLOWER_SEGMENTS_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_start_word,
   input  wire logic [7:0]         req_letter,
   input  wire logic               req_has_scale,
   input  wire logic signed [15:0] req_length_scale,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [31:0] rsp_start_x,
   output      logic signed [31:0] rsp_start_y,
   output      logic signed [31:0] rsp_end_x,
   output      logic signed [31:0] rsp_end_y,
   output      logic               rsp_flower_mesh,
   output      logic               rsp_last_segment,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   logic [63:0] symbol_codes_ff;
   logic [23:0] step_length_ff;
   logic [15:0] turn_angle_ff;
   logic [23:0] flower_radius_ff;
   logic        q_valid;
   logic        q_pop;
   item_type    q_item;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_codes_ff  <= SYMBOL_CODES_RESET;
         step_length_ff   <= STEP_LENGTH_RESET;
         turn_angle_ff    <= TURN_ANGLE_RESET;
         flower_radius_ff <= FLOWER_RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SYMBOL_CODES:  symbol_codes_ff  <= csr_wdata;
            CSR_STEP_LENGTH:   step_length_ff   <= csr_wdata[23:0];
            CSR_TURN_ANGLE:    turn_angle_ff    <= csr_wdata[15:0];
            CSR_FLOWER_RADIUS: flower_radius_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // front end: decode the letter, drop it if meaningless, queue the request
   tsg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .symbol_codes     (symbol_codes_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_word   (req_start_word),
      .req_letter       (req_letter),
      .req_has_scale    (req_has_scale),
      .req_length_scale (req_length_scale),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // back end: turtle state, stack, sine sequencer and segment output
   tsg_back #(
      .STACK_DEPTH     (STACK_DEPTH),
      .FLOWER_SEGMENTS (FLOWER_SEGMENTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .step_length      (step_length_ff),
      .turn_angle       (turn_angle_ff),
      .flower_radius    (flower_radius_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_flower_mesh  (rsp_flower_mesh),
      .rsp_last_segment (rsp_last_segment)
   );

   // never pop an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

   // the front only stalls while the queue holds requests
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_valid) else $error("stall with empty queue");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");

endmodule
`default_nettype wire

@@ rtl/tsg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_front
// Decode letters into commands and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsg_front
   import tsg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [63:0]        symbol_codes,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_start_word,
   input  wire logic [7:0]         req_letter,
   input  wire logic               req_has_scale,
   input  wire logic signed [15:0] req_length_scale,
   output      logic               q_valid,
   output      item_type           q_item,
   input  wire logic               q_pop
);

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cmd;
   logic       push;

   // lowest matching byte wins
   always_comb begin
      cmd = CMD_NONE;
      for (int i = 7; i >= 0; i--) begin
         if (symbol_codes[8*i +: 8] == req_letter) begin
            cmd = cmd_type'(4'(i));
         end
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.start_word   = req_start_word;
      slot_in.cmd          = cmd;
      slot_in.has_scale    = req_has_scale;
      slot_in.length_scale = req_length_scale;
      // drop unknown letters that carry no start flag
      push      = req_valid && !req_stall && (cmd != CMD_NONE || req_start_word);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tsg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_back
// Execute turtle commands: shared multiplier, sine sequencer, stack, output.
// ----------------------------------------------------------------------------
module tsg_back
   import tsg_pkg::*;
#(
   parameter int STACK_DEPTH     = STACK_DEPTH_DEFAULT,
   parameter int FLOWER_SEGMENTS = FLOWER_SEGMENTS_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire item_type           q_item,
   output      logic               q_pop,
   input  wire logic [23:0]        step_length,
   input  wire logic [15:0]        turn_angle,
   input  wire logic [23:0]        flower_radius,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [31:0] rsp_start_x,
   output      logic signed [31:0] rsp_start_y,
   output      logic signed [31:0] rsp_end_x,
   output      logic signed [31:0] rsp_end_y,
   output      logic               rsp_flower_mesh,
   output      logic               rsp_last_segment
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int KW = $clog2(FLOWER_SEGMENTS + 1);
   localparam int RW = $clog2(FLOWER_SEGMENTS);
   localparam int Q0 = 65536 / FLOWER_SEGMENTS;
   localparam int R0 = 65536 % FLOWER_SEGMENTS;

   state_type          state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic               sel_ff, sel_in;
   cmd_type            mode_ff, mode_in;
   logic               circle_ff, circle_in;
   logic [KW-1:0]      k_ff, k_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [15:0]        heading_ff, heading_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [32:0] len_ff, len_in;
   logic [16:0]        xv_ff, xv_in, x2_ff, x2_in;
   logic               neg_ff, neg_in;
   logic signed [17:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0] prx_ff, prx_in, pry_ff, pry_in;
   logic [15:0]        ang_ff, ang_in;
   logic [16:0]        aq_ff, aq_in;
   logic [RW-1:0]      ar_ff, ar_in;
   logic signed [51:0] prod_ff;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] o_sx_ff, o_sx_in, o_sy_ff, o_sy_in;
   logic signed [31:0] o_ex_ff, o_ex_in, o_ey_ff, o_ey_in;
   logic               o_fm_ff, o_fm_in, o_last_ff, o_last_in;

   logic [79:0]        mem [STACK_DEPTH];
   logic [79:0]        rd_data_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_wa, mem_ra;
   logic [79:0]        mem_wd;

   logic               clr, out_free;
   logic signed [31:0] eff_x, eff_y;
   logic [15:0]        eff_h, aeff;
   logic [CW-1:0]      eff_cnt;
   logic signed [17:0] scale;
   logic [18:0]        hi;
   logic [17:0]        p;
   logic [13:0]        ar14;
   logic [14:0]        tq;
   logic [16:0]        xq, rq;
   logic signed [36:0] sum_x, sum_y;
   logic [RW:0]        rsum;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = o_sx_ff;
   assign rsp_start_y      = o_sy_ff;
   assign rsp_end_x        = o_ex_ff;
   assign rsp_end_y        = o_ey_ff;
   assign rsp_flower_mesh  = o_fm_ff;
   assign rsp_last_segment = o_last_ff;

   always_comb begin
      clr      = q_item.start_word;
      eff_x    = clr ? 32'sd0 : pos_x_ff;
      eff_y    = clr ? 32'sd0 : pos_y_ff;
      eff_h    = clr ? HEADING_RESET : heading_ff;
      eff_cnt  = clr ? '0 : cnt_ff;
      scale    = q_item.has_scale ? 18'(q_item.length_scale) : 18'sd256;
      out_free = !rsp_valid_ff || !rsp_stall;
      hi       = prod_ff[34:16];
      aeff     = sel_ff ? ang_ff : ang_ff + HEADING_RESET;
      ar14     = aeff[13:0];
      tq       = aeff[14] ? 15'd16384 - {1'b0, ar14} : {1'b0, ar14};
      xq       = {tq, 2'b00};
      rq       = (hi > 19'd65536) ? 17'd65536 : hi[16:0];
      sum_x    = 37'(pos_x_ff) + 37'($signed(prod_ff[51:16]));
      sum_y    = 37'(pos_y_ff) + 37'($signed(prod_ff[51:16]));
      rsum     = {1'b0, ar_ff} + (RW+1)'(R0);
   end

   always_comb begin
      state_in   = state_ff;   phase_in  = phase_ff;  sel_in   = sel_ff;
      mode_in    = mode_ff;    circle_in = circle_ff; k_in     = k_ff;
      pos_x_in   = pos_x_ff;   pos_y_in  = pos_y_ff;  heading_in = heading_ff;
      cnt_in     = cnt_ff;     len_in    = len_ff;    xv_in    = xv_ff;
      x2_in      = x2_ff;      neg_in    = neg_ff;    cos_in   = cos_ff;
      sin_in     = sin_ff;     nx_in     = nx_ff;     ny_in    = ny_ff;
      prx_in     = prx_ff;     pry_in    = pry_ff;    ang_in   = ang_ff;
      aq_in      = aq_ff;      ar_in     = ar_ff;
      o_sx_in    = o_sx_ff;    o_sy_in   = o_sy_ff;   o_ex_in  = o_ex_ff;
      o_ey_in    = o_ey_ff;    o_fm_in   = o_fm_ff;   o_last_in = o_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop  = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      p      = '0;
      mem_we = 1'b0;
      mem_wa = eff_cnt[IW-1:0];
      mem_wd = {eff_x, eff_y, eff_h};
      mem_ra = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               pos_x_in   = eff_x;
               pos_y_in   = eff_y;
               heading_in = eff_h;
               cnt_in     = eff_cnt;
               mode_in    = q_item.cmd;
               case (q_item.cmd)
                  CMD_DRAW, CMD_MOVE: begin
                     mul_a    = 34'(step_length);
                     mul_b    = scale;
                     state_in = ST_LEN;
                  end
                  CMD_FLOWER: begin
                     mul_a    = 34'(step_length);
                     mul_b    = STEM_FRAC;
                     state_in = ST_LEN;
                  end
                  CMD_LEFT:   heading_in = eff_h + turn_angle;
                  CMD_RIGHT:  heading_in = eff_h - turn_angle;
                  CMD_AROUND: heading_in = eff_h + 16'h8000;
                  CMD_PUSH: begin
                     if (eff_cnt < CW'(STACK_DEPTH)) begin
                        mem_we = 1'b1;
                        cnt_in = eff_cnt + CW'(1);
                     end
                  end
                  CMD_POP: begin
                     if (eff_cnt != '0) begin
                        cnt_in   = eff_cnt - CW'(1);
                        mem_ra   = cnt_in[IW-1:0];
                        state_in = ST_POP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LEN: begin
            len_in    = (mode_ff == CMD_FLOWER) ? prod_ff[48:16] : prod_ff[40:8];
            ang_in    = heading_ff;
            circle_in = 1'b0;
            sel_in    = 1'b0;
            phase_in  = 3'd0;
            state_in  = ST_TRIG;
         end
         ST_TRIG: begin
            // quarter-wave polynomial, its products issued in turn on the shared multiplier
            case (phase_ff)
               3'd0: begin
                  xv_in  = xq;
                  neg_in = aeff[15];
                  mul_a  = 34'(xq);
                  mul_b  = $signed({1'b0, xq});
               end
               3'd1: begin
                  x2_in = hi[16:0];
                  mul_a = 34'(hi);
                  mul_b = 18'sd307;
               end
               3'd2, 3'd3, 3'd4: begin
                  if (phase_ff == 3'd2) begin
                     p = 18'd5223 - 18'(hi);
                  end else if (phase_ff == 3'd3) begin
                     p = 18'd42334 - 18'(hi);
                  end else begin
                     p = 18'd102944 - 18'(hi);
                  end
                  mul_a = 34'(p);
                  mul_b = (phase_ff == 3'd4) ? $signed({1'b0, xv_ff}) : $signed({1'b0, x2_ff});
               end
               default: begin
                  if (!sel_ff) begin
                     cos_in = neg_ff ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
                     sel_in = 1'b1;
                  end else begin
                     sin_in   = neg_ff ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
                     state_in = ST_PROJ;
                  end
               end
            endcase
            phase_in = (phase_ff == 3'd5) ? 3'd0 : phase_ff + 3'd1;
         end
         ST_PROJ: begin
            case (phase_ff)
               3'd0: begin
                  mul_a = 34'(len_ff);
                  mul_b = cos_ff;
               end
               3'd1: begin
                  nx_in = sat32(sum_x);
                  mul_a = 34'(len_ff);
                  mul_b = sin_ff;
               end
               default: begin
                  ny_in    = sat32(sum_y);
                  state_in = ST_NEXT;
               end
            endcase
            phase_in = (phase_ff == 3'd2) ? 3'd0 : phase_ff + 3'd1;
         end
         ST_NEXT: begin
            if (!circle_ff) begin
               if (mode_ff == CMD_MOVE) begin
                  pos_x_in = nx_ff;
                  pos_y_in = ny_ff;
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  o_sx_in  = pos_x_ff;  o_sy_in = pos_y_ff;
                  o_ex_in  = nx_ff;     o_ey_in = ny_ff;
                  o_fm_in  = 1'b0;
                  o_last_in = (mode_ff == CMD_DRAW);
                  pos_x_in = nx_ff;
                  pos_y_in = ny_ff;
                  if (mode_ff == CMD_DRAW) begin
                     state_in = ST_IDLE;
                  end else begin
                     // circle around the stem tip
                     len_in    = 33'(flower_radius);
                     circle_in = 1'b1;
                     k_in      = '0;
                     ang_in    = '0;
                     aq_in     = '0;
                     ar_in     = '0;
                     sel_in    = 1'b0;
                     state_in  = ST_TRIG;
                  end
               end
            end else if (k_ff == '0 || out_free) begin
               if (k_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  o_sx_in  = prx_ff;  o_sy_in = pry_ff;
                  o_ex_in  = nx_ff;   o_ey_in = ny_ff;
                  o_fm_in  = 1'b1;
                  o_last_in = (k_ff == KW'(FLOWER_SEGMENTS));
               end
               prx_in = nx_ff;
               pry_in = ny_ff;
               if (k_ff == KW'(FLOWER_SEGMENTS)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + KW'(1);
                  // advance floor(k * 65536 / segments)
                  if (rsum >= (RW+1)'(FLOWER_SEGMENTS)) begin
                     ar_in = RW'(rsum - (RW+1)'(FLOWER_SEGMENTS));
                     aq_in = aq_ff + 17'(Q0) + 17'd1;
                  end else begin
                     ar_in = rsum[RW-1:0];
                     aq_in = aq_ff + 17'(Q0);
                  end
                  ang_in   = aq_in[15:0];
                  sel_in   = 1'b0;
                  state_in = ST_TRIG;
               end
            end
         end
         ST_POP: begin
            pos_x_in   = rd_data_ff[79:48];
            pos_y_in   = rd_data_ff[47:16];
            heading_in = rd_data_ff[15:0];
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 3'd0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= HEADING_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff <= sel_in;   mode_ff <= mode_in;   circle_ff <= circle_in;
      k_ff   <= k_in;     len_ff  <= len_in;    xv_ff  <= xv_in;
      x2_ff  <= x2_in;    neg_ff  <= neg_in;    cos_ff <= cos_in;
      sin_ff <= sin_in;   nx_ff   <= nx_in;     ny_ff  <= ny_in;
      prx_ff <= prx_in;   pry_ff  <= pry_in;    ang_ff <= ang_in;
      aq_ff  <= aq_in;    ar_ff   <= ar_in;
      o_sx_ff <= o_sx_in; o_sy_ff <= o_sy_in;   o_ex_ff <= o_ex_in;
      o_ey_ff <= o_ey_in; o_fm_ff <= o_fm_in;   o_last_ff <= o_last_in;
      prod_ff <= 52'(mul_a * mul_b);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

endmodule
`default_nettype wire

@@ bench/turtle_segment_generator_core_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_segment_generator_core_checker
// Watches the request, segment and register channels, predicts the segments
// from the turtle state and compares each one taken against the oldest due.
// ----------------------------------------------------------------------------
module turtle_segment_generator_core_checker
   import tsg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_start_word,
   input  wire logic [7:0]         req_letter,
   input  wire logic               req_has_scale,
   input  wire logic signed [15:0] req_length_scale,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [31:0] rsp_start_x,
   input  wire logic signed [31:0] rsp_start_y,
   input  wire logic signed [31:0] rsp_end_x,
   input  wire logic signed [31:0] rsp_end_y,
   input  wire logic               rsp_flower_mesh,
   input  wire logic               rsp_last_segment,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_wdata,
   output int                      fail_count,
   output int                      segments_due
);

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int PETALS = FLOWER_SEGMENTS_DEFAULT;

   typedef struct packed {
      logic signed [31:0] sx, sy, ex, ey;
      logic               flower, last;
   } segment_type;

   segment_type        due_q[$];
   logic [63:0]        codes;
   logic [23:0]        step_len, radius;
   logic [15:0]        turn;
   logic signed [31:0] tx, ty;
   logic [15:0]        head;
   logic [63:0]        saved_pos[DEPTH];
   logic [15:0]        saved_head[DEPTH];
   int                 depth_used;

   assign segments_due = due_q.size();

   function automatic longint quarter_sine(input longint t);
      longint x, x2, p, r;
      x  = t << 2;
      x2 = (x * x) >>> 16;
      p  = 5223 - ((x2 * 307) >>> 16);
      p  = 42334 - ((x2 * p) >>> 16);
      p  = 102944 - ((x2 * p) >>> 16);
      r  = (x * p) >>> 16;
      if (r > 65536) r = 65536;
      return r;
   endfunction

   function automatic longint sine(input logic [15:0] a);
      longint r;
      r = a[13:0];
      case (a[15:14])
         2'd0: return quarter_sine(r);
         2'd1: return quarter_sine(16384 - r);
         2'd2: return -quarter_sine(r);
         default: return -quarter_sine(16384 - r);
      endcase
   endfunction

   function automatic logic signed [31:0] clamp(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // append one segment to the due list
   task automatic add_due(input segment_type s);
      due_q = {due_q, s};
   endtask

   // arithmetic shift of a signed product floors, as required
   task automatic advance(input logic signed [31:0] x0, y0, input logic [15:0] a,
                          input longint len, output logic signed [31:0] x1, y1);
      x1 = clamp(longint'(x0) + ((len * sine(a + 16'd16384)) >>> 16));
      y1 = clamp(longint'(y0) + ((len * sine(a)) >>> 16));
   endtask

   task automatic predict_symbol();
      cmd_type            cmd;
      longint             scale, len;
      logic signed [31:0] nx, ny, cx0, cy0, cx1, cy1;
      cmd = CMD_NONE;
      if (req_start_word) begin
         tx = 0; ty = 0; head = HEADING_RESET; depth_used = 0;
      end
      for (int i = 7; i >= 0; i--)
         if (codes[8*i +: 8] == req_letter) cmd = cmd_type'(i);
      case (cmd)
         CMD_DRAW, CMD_MOVE: begin
            scale = req_has_scale ? longint'(req_length_scale) : 256;
            len = (longint'(step_len) * scale) >>> 8;
            advance(tx, ty, head, len, nx, ny);
            if (cmd == CMD_DRAW) add_due('{tx, ty, nx, ny, 1'b0, 1'b1});
            tx = nx; ty = ny;
         end
         CMD_FLOWER: begin
            len = (longint'(step_len) * 39322) >>> 16;
            advance(tx, ty, head, len, nx, ny);
            add_due('{tx, ty, nx, ny, 1'b0, 1'b0});
            for (int k = 0; k < PETALS; k++) begin
               advance(nx, ny, 16'((k * 65536) / PETALS), longint'(radius), cx0, cy0);
               advance(nx, ny, 16'(((k + 1) * 65536) / PETALS), longint'(radius),
                       cx1, cy1);
               add_due('{cx0, cy0, cx1, cy1, 1'b1, k == PETALS - 1});
            end
            tx = nx; ty = ny;
         end
         CMD_LEFT:   head = head + turn;
         CMD_RIGHT:  head = head - turn;
         CMD_AROUND: head = head + 16'd32768;
         CMD_PUSH: if (depth_used < DEPTH) begin
            saved_pos[depth_used] = {tx, ty};
            saved_head[depth_used] = head;
            depth_used++;
         end
         CMD_POP: if (depth_used > 0) begin
            depth_used--;
            {tx, ty} = saved_pos[depth_used];
            head = saved_head[depth_used];
         end
         default: ;
      endcase
   endtask

   task automatic compare_segment();
      segment_type want;
      if (due_q.size() == 0) begin
         $error("segment taken with none due");
         fail_count++;
         return;
      end
      want = due_q.pop_front();
      if (rsp_start_x !== want.sx) begin
         $error("start_x: expected %0d, got %0d", want.sx, rsp_start_x); fail_count++;
      end
      if (rsp_start_y !== want.sy) begin
         $error("start_y: expected %0d, got %0d", want.sy, rsp_start_y); fail_count++;
      end
      if (rsp_end_x !== want.ex) begin
         $error("end_x: expected %0d, got %0d", want.ex, rsp_end_x); fail_count++;
      end
      if (rsp_end_y !== want.ey) begin
         $error("end_y: expected %0d, got %0d", want.ey, rsp_end_y); fail_count++;
      end
      if (rsp_flower_mesh !== want.flower) begin
         $error("flower_mesh: expected %0d, got %0d", want.flower, rsp_flower_mesh);
         fail_count++;
      end
      if (rsp_last_segment !== want.last) begin
         $error("last_segment: expected %0d, got %0d", want.last, rsp_last_segment);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         codes = SYMBOL_CODES_RESET; step_len = STEP_LENGTH_RESET;
         turn = TURN_ANGLE_RESET; radius = FLOWER_RADIUS_RESET;
         tx = 0; ty = 0; head = HEADING_RESET; depth_used = 0;
         due_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SYMBOL_CODES:  codes = csr_wdata;
               CSR_STEP_LENGTH:   step_len = csr_wdata[23:0];
               CSR_TURN_ANGLE:    turn = csr_wdata[15:0];
               CSR_FLOWER_RADIUS: radius = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_segment();
         if (req_valid && !req_stall) predict_symbol();
      end
   end

endmodule

@@ bench/turtle_segment_generator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_segment_generator_core_tb
// Drives symbol streams and register settings into the turtle core; the
// checker beside it predicts and compares every segment.
// ----------------------------------------------------------------------------
module turtle_segment_generator_core_tb;
   import tsg_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_start_word = 1'b0;
   logic [7:0]         req_letter = 8'd0;
   logic               req_has_scale = 1'b0;
   logic signed [15:0] req_length_scale = 16'sd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic               rsp_flower_mesh, rsp_last_segment;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = 2'd0;
   logic [63:0]        csr_wdata = 64'd0;
   int                 fail_count;
   int                 segments_due;
   int                 cycle_count = 0;
   int                 stall_mode = 0;
   logic [63:0]        active_codes = SYMBOL_CODES_RESET;

   always #4 clock = ~clock;

   turtle_segment_generator_core u_dut (.*);

   turtle_segment_generator_core_checker u_checker (.*);

   // cycle watchdog: a hung block ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure: mode changes now and then, including no stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 15) < 13);
      endcase
   end

   // write one register; only called with the block idle
   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SYMBOL_CODES) active_codes = value;
   endtask

   // hold a request until taken; a random gap may follow
   task automatic send_symbol(input logic sw, input logic [7:0] ltr, input logic hs,
                              input logic [15:0] sc, input int gap);
      req_valid <= 1'b1;
      req_start_word <= sw;
      req_letter <= ltr;
      req_has_scale <= hs;
      req_length_scale <= sc;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain the segment queue, then let a flower's tail finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segments_due != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [7:0] code_of(input cmd_type c);
      return active_codes[8*c +: 8];
   endfunction

   // pick a letter; a few are random bytes, flowers are thinned out
   function automatic logic [7:0] pick_letter(input int r);
      cmd_type c;
      if (r < 5) return 8'($urandom);
      c = cmd_type'($urandom_range(0, 7));
      if (c == CMD_FLOWER && $urandom_range(0, 2) != 0) c = CMD_DRAW;
      return code_of(c);
   endfunction

   task automatic random_phase(input int count);
      int burst, sent;
      logic [7:0] ltr;
      logic sw;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            ltr = pick_letter($urandom_range(0, 99));
            sw = ($urandom_range(0, 39) == 0);
            send_symbol(sw, ltr, 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                        16'($urandom_range(0, 1023)) - 16'd512,
                        (i == burst - 1) ? $urandom_range(0, 20) : 0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command at reset settings, scale extremes, stack edges
      send_symbol(1'b1, code_of(CMD_DRAW), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_DRAW), 1'b1, 16'h7FFF, 0);
      send_symbol(1'b0, code_of(CMD_DRAW), 1'b1, 16'h8000, 0);
      send_symbol(1'b0, code_of(CMD_MOVE), 1'b1, 16'hFFFF, 0);
      send_symbol(1'b0, code_of(CMD_LEFT), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_FLOWER), 1'b0, 16'h0000, 2);
      send_symbol(1'b0, code_of(CMD_RIGHT), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_POP), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_PUSH), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_AROUND), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_DRAW), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_POP), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, 8'hFF, 1'b1, 16'h5555, 0);
      for (int i = 0; i < 34; i++)
         send_symbol(1'b0, code_of(CMD_PUSH), 1'b0, 16'h0000, 0);
      settle();

      // extreme step and radius: saturate positions, then a fresh word
      write_reg(CSR_STEP_LENGTH, 64'hFFFFFF);
      write_reg(CSR_FLOWER_RADIUS, 64'hFFFFFF);
      write_reg(CSR_TURN_ANGLE, 64'hFFFF);
      for (int i = 0; i < 6; i++)
         send_symbol(1'b0, code_of(CMD_DRAW), 1'b1, 16'h7FFF, 0);
      send_symbol(1'b0, code_of(CMD_FLOWER), 1'b0, 16'h0000, 0);
      send_symbol(1'b0, code_of(CMD_LEFT), 1'b0, 16'h0000, 0);
      send_symbol(1'b1, code_of(CMD_DRAW), 1'b1, 16'h8000, 0);
      settle();

      random_phase(150);
      settle();

      // other letters, duplicates so the lowest byte wins, zero settings
      write_reg(CSR_SYMBOL_CODES, {$urandom, $urandom} | 64'h0101_0101_0101_0101);
      write_reg(CSR_SYMBOL_CODES, 64'h4142_4344_4141_4546);
      write_reg(CSR_STEP_LENGTH, 64'd0);
      write_reg(CSR_TURN_ANGLE, 64'd0);
      write_reg(CSR_FLOWER_RADIUS, 64'd0);
      random_phase(60);
      settle();

      write_reg(CSR_SYMBOL_CODES, 64'hFF00_7F80_AA55_0102);
      write_reg(CSR_STEP_LENGTH, 64'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CSR_TURN_ANGLE, 64'($urandom));
      write_reg(CSR_FLOWER_RADIUS, 64'($urandom_range(0, 24'hFFFFFF)));
      random_phase(120);
      settle();

      write_reg(CSR_SYMBOL_CODES, SYMBOL_CODES_RESET);
      write_reg(CSR_STEP_LENGTH, 64'd40000);
      write_reg(CSR_TURN_ANGLE, 64'd8192);
      write_reg(CSR_FLOWER_RADIUS, 64'd20000);
      random_phase(100);
      settle();

      if (fail_count == 0 && segments_due == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tsg_pkg.sv
rtl/tsg_front.sv
rtl/tsg_back.sv
rtl/turtle_segment_generator_core.sv
bench/turtle_segment_generator_core_checker.sv
bench/turtle_segment_generator_core_tb.sv
